/* design/split_direct_mapped_cache_tags_top_defines.svh */
// Assertion macros shared by the split cache tag design.
// Expects clk and rst_n in the scope that uses them; no other dependencies.
`ifndef SPLIT_DIRECT_MAPPED_CACHE_TAGS_TOP_DEFINES_SVH
`define SPLIT_DIRECT_MAPPED_CACHE_TAGS_TOP_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define SDMCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define SDMCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sdmct_pkg.sv */
// Shared widths, register indexes, command struct and counter helpers for the
// split direct-mapped cache tag design. No dependencies.
package sdmct_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned LINES      = 1 << IDX_W;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned SHIFT_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_INDEX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INSTR_INDEX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INSTR_OFFSET = 2'd3;

  localparam logic [CFG_DATA_W-1:0] RST_INDEX_BITS  = 4'd6;
  localparam logic [CFG_DATA_W-1:0] RST_OFFSET_BITS = 4'd4;
  localparam logic [CFG_DATA_W-1:0] MAX_INDEX_BITS  = CFG_DATA_W'(IDX_W);

  localparam logic SEL_DATA  = 1'b0;
  localparam logic SEL_INSTR = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic             clr_en;
    logic [IDX_W-1:0] clr_addr;
    logic             accept;
    logic             commit;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] acc;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
  } cnt_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* design/sdmct_ifs.sv */
// Valid/ready channel interfaces for the split cache tag design.
// Depends on sdmct_pkg for field widths.
interface sdmct_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cache_select;
  logic [sdmct_pkg::ADDR_W-1:0]  address;
  modport source (output valid, cache_select, address, input ready);
  modport sink   (input valid, cache_select, address, output ready);
endinterface

interface sdmct_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [sdmct_pkg::IDX_W-1:0]  line_index;
  logic [sdmct_pkg::TAG_W-1:0]  tag_value;
  logic [sdmct_pkg::CNT_W-1:0]  access_count;
  logic [sdmct_pkg::CNT_W-1:0]  hit_count;
  logic [sdmct_pkg::CNT_W-1:0]  miss_count;
  modport source (output valid, hit, line_index, tag_value, access_count, hit_count,
                  miss_count, input ready);
  modport sink   (input valid, hit, line_index, tag_value, access_count, hit_count,
                  miss_count, output ready);
endinterface

interface sdmct_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sdmct_pkg::CFG_IDX_W-1:0]   index;
  logic [sdmct_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/sdmct_ctrl.sv */
// Sequencing controller: post-reset clearing pass, accept, commit, output valid.
// Depends on sdmct_pkg and the shared assertion macro header.
`include "split_direct_mapped_cache_tags_top_defines.svh"

module sdmct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output sdmct_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_CMP} state_t;

  state_t                          state_r, state_nxt;
  logic [sdmct_pkg::IDX_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd.clr_en   = (state_r == ST_CLEAR);
    cmd.clr_addr = clr_cnt_r;
    cmd.accept   = (state_r == ST_IDLE) && in_valid;
    cmd.commit   = (state_r == ST_CMP) && out_free;

    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && !out_ready);

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + sdmct_pkg::IDX_W'(1);
        if (clr_cnt_r == sdmct_pkg::IDX_W'(sdmct_pkg::LINES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        // hold here until the output register is free
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `SDMCT_ASSERT_SAME(a_commit_room, cmd.commit, !out_valid_r || out_ready,
                     "commit overwrote a pending output word")
  `SDMCT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
                     "accepted a word while one is in flight")
  `SDMCT_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid,
                     "committed word not presented")
  `SDMCT_ASSERT_NEXT(a_clear_done,
                     cmd.clr_en && (clr_cnt_r == sdmct_pkg::IDX_W'(sdmct_pkg::LINES - 1)),
                     in_ready, "clearing pass did not end in idle")

endmodule

/* design/sdmct_dpath.sv */
// Datapath: configuration registers, address split, tag memories, counters, output word.
// Depends on sdmct_pkg; driven by sdmct_ctrl commands.
module sdmct_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sdmct_pkg::dp_cmd_t                 cmd,
  input  logic                               in_cache_select,
  input  logic [sdmct_pkg::ADDR_W-1:0]       in_address,
  input  logic                               cfg_we,
  input  logic [sdmct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdmct_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                               out_hit,
  output logic [sdmct_pkg::IDX_W-1:0]        out_line_index,
  output logic [sdmct_pkg::TAG_W-1:0]        out_tag_value,
  output logic [sdmct_pkg::CNT_W-1:0]        out_access_count,
  output logic [sdmct_pkg::CNT_W-1:0]        out_hit_count,
  output logic [sdmct_pkg::CNT_W-1:0]        out_miss_count
);

  localparam int unsigned ENT_W = sdmct_pkg::TAG_W + 1;

  logic [sdmct_pkg::CFG_DATA_W-1:0] d_ib_r, d_ob_r, i_ib_r, i_ob_r;
  logic [sdmct_pkg::CFG_DATA_W-1:0] ib_raw, ib_eff, ob;
  logic [sdmct_pkg::IDX_W-1:0]      idx_mask, lk_idx;
  logic [sdmct_pkg::ADDR_W-1:0]     addr_sh;
  logic [sdmct_pkg::SHIFT_W-1:0]    tag_sh;
  logic [sdmct_pkg::TAG_W-1:0]      lk_tag;

  logic                             sel_r;
  logic [sdmct_pkg::IDX_W-1:0]      idx_r;
  logic [sdmct_pkg::TAG_W-1:0]      tag_r;

  logic [ENT_W-1:0] dmem [sdmct_pkg::LINES];
  logic [ENT_W-1:0] imem [sdmct_pkg::LINES];
  logic [ENT_W-1:0] d_rd_r, i_rd_r, rd_ent;
  logic             hit, dmem_we, imem_we;

  sdmct_pkg::cnt_t  cnt_r [2];
  sdmct_pkg::cnt_t  cur_cnt, upd_cnt;

  logic                             out_hit_r;
  logic [sdmct_pkg::IDX_W-1:0]      out_idx_r;
  logic [sdmct_pkg::TAG_W-1:0]      out_tag_r;
  sdmct_pkg::cnt_t                  out_cnt_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_ib_r <= sdmct_pkg::RST_INDEX_BITS;
      d_ob_r <= sdmct_pkg::RST_OFFSET_BITS;
      i_ib_r <= sdmct_pkg::RST_INDEX_BITS;
      i_ob_r <= sdmct_pkg::RST_OFFSET_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        sdmct_pkg::REG_DATA_INDEX:   d_ib_r <= cfg_data;
        sdmct_pkg::REG_DATA_OFFSET:  d_ob_r <= cfg_data;
        sdmct_pkg::REG_INSTR_INDEX:  i_ib_r <= cfg_data;
        sdmct_pkg::REG_INSTR_OFFSET: i_ob_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Split the incoming address with the selected cache's geometry.
  always_comb begin
    ib_raw   = (in_cache_select == sdmct_pkg::SEL_INSTR) ? i_ib_r : d_ib_r;
    ob       = (in_cache_select == sdmct_pkg::SEL_INSTR) ? i_ob_r : d_ob_r;
    ib_eff   = (ib_raw > sdmct_pkg::MAX_INDEX_BITS) ? sdmct_pkg::MAX_INDEX_BITS : ib_raw;
    idx_mask = ~({sdmct_pkg::IDX_W{1'b1}} << ib_eff);
    addr_sh  = in_address >> ob;
    lk_idx   = addr_sh[sdmct_pkg::IDX_W-1:0] & idx_mask;
    tag_sh   = sdmct_pkg::SHIFT_W'(ob) + sdmct_pkg::SHIFT_W'(ib_eff);
    lk_tag   = sdmct_pkg::TAG_W'(in_address >> tag_sh);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sel_r <= in_cache_select;
      idx_r <= lk_idx;
      tag_r <= lk_tag;
    end
  end

  // Tag memories: entry is {valid, tag}.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      d_rd_r <= dmem[lk_idx];
      i_rd_r <= imem[lk_idx];
    end
  end

  assign rd_ent  = (sel_r == sdmct_pkg::SEL_INSTR) ? i_rd_r : d_rd_r;
  assign hit     = rd_ent[ENT_W-1] && (rd_ent[sdmct_pkg::TAG_W-1:0] == tag_r);
  assign dmem_we = cmd.commit && !hit && (sel_r == sdmct_pkg::SEL_DATA);
  assign imem_we = cmd.commit && !hit && (sel_r == sdmct_pkg::SEL_INSTR);

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      dmem[cmd.clr_addr] <= '0;
    end else if (dmem_we) begin
      dmem[idx_r] <= {1'b1, tag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      imem[cmd.clr_addr] <= '0;
    end else if (imem_we) begin
      imem[idx_r] <= {1'b1, tag_r};
    end
  end

  // Saturating counters per cache.
  always_comb begin
    cur_cnt        = cnt_r[sel_r];
    upd_cnt.acc    = sdmct_pkg::sat_inc(cur_cnt.acc);
    upd_cnt.hits   = hit ? sdmct_pkg::sat_inc(cur_cnt.hits) : cur_cnt.hits;
    upd_cnt.misses = hit ? cur_cnt.misses : sdmct_pkg::sat_inc(cur_cnt.misses);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
    end else if (cmd.commit) begin
      cnt_r[sel_r] <= upd_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r <= hit;
      out_idx_r <= idx_r;
      out_tag_r <= tag_r;
      out_cnt_r <= upd_cnt;
    end
  end

  assign out_hit          = out_hit_r;
  assign out_line_index   = out_idx_r;
  assign out_tag_value    = out_tag_r;
  assign out_access_count = out_cnt_r.acc;
  assign out_hit_count    = out_cnt_r.hits;
  assign out_miss_count   = out_cnt_r.misses;

endmodule

/* design/split_direct_mapped_cache_tags_top.sv */
// Channel  | Dir | Payload                                              | Handshake
// in_ch    | in  | cache_select, address                                | valid/ready
// out_ch   | out | hit, line_index, tag_value, access/hit/miss counts   | valid/ready
// cfg_ch   | in  | index (register 0..3), data (4 bits)                 | valid/ready
//
// Each word passes an accept step, which reads both tag memories, and a compare step,
// which compares, fills on a miss, bumps the counters and loads the output register.
// After reset a clearing pass wipes all 1024 entries of both tag memories (one entry a
// cycle); in_ch is not ready during it, cfg_ch always is.
// A result waiting on out_ch does not block accepting the next word; that word holds
// in the compare step until the output register is taken.
// Depends on sdmct_pkg, the interfaces in sdmct_ifs, sdmct_ctrl and sdmct_dpath.
module split_direct_mapped_cache_tags_top (
  input logic       clk,
  input logic       rst_n,
  sdmct_in_if.sink  in_ch,
  sdmct_out_if.source out_ch,
  sdmct_cfg_if.sink cfg_ch
);

  sdmct_pkg::dp_cmd_t cmd;

  // Configuration writes are always taken; they must arrive while the block is idle, which it does not enforce.
  assign cfg_ch.ready = 1'b1;

  // Sequencing: clearing pass, accept, commit and output valid.
  sdmct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Address split, tag lookup and fill, counters and the output word.
  sdmct_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_cache_select  (in_ch.cache_select),
    .in_address       (in_ch.address),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_hit          (out_ch.hit),
    .out_line_index   (out_ch.line_index),
    .out_tag_value    (out_ch.tag_value),
    .out_access_count (out_ch.access_count),
    .out_hit_count    (out_ch.hit_count),
    .out_miss_count   (out_ch.miss_count)
  );

endmodule
